>>> design/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants of the 3D point transform
// Mode codes, CORDIC widths and constants, the arctangent table and the
// control word that travels with each transaction down the pipeline.
// ----------------------------------------------------------------------------
package ptd_pkg;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_ROT_X     = 2'd1,
    MODE_ROT_Y     = 2'd2,
    MODE_ROT_Z     = 2'd3
  } ptd_mode_t;

  // Angle in Q4.12 radians.
  localparam int ANG_W = 16;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 16'sd25736;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 16'sd12868;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd6434;

  // CORDIC angle accumulator in Q28, vector components in Q30.
  localparam int Z_W  = 32;
  localparam int XY_W = 34;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XY_W-1:0] ROUND_Q14   = 34'sd8192;

  // Sine and cosine in Q16.
  localparam int K_W = 18;

  typedef struct packed {
    logic      valid;
    ptd_mode_t mode;
    logic      neg;
  } ptd_ctrl_t;

  function automatic logic signed [Z_W-1:0] atan_q28(input int unsigned idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:  r = 32'sd210828714;
      1:  r = 32'sd124459457;
      2:  r = 32'sd65760959;
      3:  r = 32'sd33381290;
      4:  r = 32'sd16755422;
      5:  r = 32'sd8385879;
      6:  r = 32'sd4193963;
      7:  r = 32'sd2097109;
      8:  r = 32'sd1048571;
      9:  r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/ptd_if.sv
// ----------------------------------------------------------------------------
// ptd_if: point and image channels of the 3D point transform
// Valid/ready channels; a transaction completes on a clock edge with both high.
// ----------------------------------------------------------------------------
interface ptd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] delta_x;
  logic signed [31:0] delta_y;
  logic signed [31:0] delta_z;
  logic signed [15:0] angle;

  modport source (
    output valid, mode, point_x, point_y, point_z, delta_x, delta_y, delta_z, angle,
    input  ready
  );
  modport sink (
    input  valid, mode, point_x, point_y, point_z, delta_x, delta_y, delta_z, angle,
    output ready
  );
endinterface

interface ptd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] image_x;
  logic signed [31:0] image_y;
  logic signed [31:0] image_z;
  logic               saturated;

  modport source (
    output valid, image_x, image_y, image_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, image_x, image_y, image_z, saturated,
    output ready
  );
endinterface

>>> design/ptd_prep.sv
// ----------------------------------------------------------------------------
// ptd_prep: entry stage of the 3D point transform
// Reduces the angle to [-pi/2, pi/2], seeds the CORDIC vector and forms the
// translated point for mode 0 (the plain point for the rotations).
// ----------------------------------------------------------------------------
module ptd_prep #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  ptd_in_if.sink                               point_in,
  input  logic                                 ready_next,
  output ptd_pkg::ptd_ctrl_t                   ctrl,
  output logic signed [ptd_pkg::XY_W-1:0]      x,
  output logic signed [ptd_pkg::XY_W-1:0]      y,
  output logic signed [ptd_pkg::Z_W-1:0]       z,
  output logic signed [COORD_WIDTH:0]          vx,
  output logic signed [COORD_WIDTH:0]          vy,
  output logic signed [COORD_WIDTH:0]          vz
);

  logic signed [COORD_WIDTH-1:0] pxc, pyc, pzc, dxc, dyc, dzc;
  logic signed [ptd_pkg::ANG_W-1:0] a_wrap, a_fold;
  logic neg;
  logic en;
  ptd_pkg::ptd_mode_t mode;
  logic signed [COORD_WIDTH:0] vx_next, vy_next, vz_next;

  // Coordinates are read at COORD_WIDTH bits; a wider core sees them as positive.
  if (COORD_WIDTH <= 32) begin : g_narrow
    assign pxc = $signed(point_in.point_x[COORD_WIDTH-1:0]);
    assign pyc = $signed(point_in.point_y[COORD_WIDTH-1:0]);
    assign pzc = $signed(point_in.point_z[COORD_WIDTH-1:0]);
    assign dxc = $signed(point_in.delta_x[COORD_WIDTH-1:0]);
    assign dyc = $signed(point_in.delta_y[COORD_WIDTH-1:0]);
    assign dzc = $signed(point_in.delta_z[COORD_WIDTH-1:0]);
  end else begin : g_wide
    assign pxc = $signed({{(COORD_WIDTH-32){1'b0}}, point_in.point_x});
    assign pyc = $signed({{(COORD_WIDTH-32){1'b0}}, point_in.point_y});
    assign pzc = $signed({{(COORD_WIDTH-32){1'b0}}, point_in.point_z});
    assign dxc = $signed({{(COORD_WIDTH-32){1'b0}}, point_in.delta_x});
    assign dyc = $signed({{(COORD_WIDTH-32){1'b0}}, point_in.delta_y});
    assign dzc = $signed({{(COORD_WIDTH-32){1'b0}}, point_in.delta_z});
  end

  assign mode = ptd_pkg::ptd_mode_t'(point_in.mode);
  assign en = !ctrl.valid || ready_next;
  assign point_in.ready = en;

  always_comb begin
    // One wrap by 2*pi covers the whole Q4.12 input range.
    if (point_in.angle > ptd_pkg::ANG_PI) begin
      a_wrap = point_in.angle - ptd_pkg::ANG_TWO_PI;
    end else if (point_in.angle < -ptd_pkg::ANG_PI) begin
      a_wrap = point_in.angle + ptd_pkg::ANG_TWO_PI;
    end else begin
      a_wrap = point_in.angle;
    end
    // Outside the right half plane, rotate by pi and negate sine and cosine later.
    if (a_wrap > ptd_pkg::ANG_HALF_PI) begin
      a_fold = a_wrap - ptd_pkg::ANG_PI;
      neg = 1'b1;
    end else if (a_wrap < -ptd_pkg::ANG_HALF_PI) begin
      a_fold = a_wrap + ptd_pkg::ANG_PI;
      neg = 1'b1;
    end else begin
      a_fold = a_wrap;
      neg = 1'b0;
    end
    if (mode == ptd_pkg::MODE_TRANSLATE) begin
      vx_next = (COORD_WIDTH+1)'(pxc) + (COORD_WIDTH+1)'(dxc);
      vy_next = (COORD_WIDTH+1)'(pyc) + (COORD_WIDTH+1)'(dyc);
      vz_next = (COORD_WIDTH+1)'(pzc) + (COORD_WIDTH+1)'(dzc);
    end else begin
      vx_next = (COORD_WIDTH+1)'(pxc);
      vy_next = (COORD_WIDTH+1)'(pyc);
      vz_next = (COORD_WIDTH+1)'(pzc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= point_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl.mode <= mode;
      ctrl.neg  <= neg;
      x  <= ptd_pkg::CORDIC_GAIN;
      y  <= '0;
      z  <= $signed({a_fold, 16'b0});
      vx <= vx_next;
      vy <= vy_next;
      vz <= vz_next;
    end
  end

endmodule

>>> design/ptd_cordic_cell.sv
// ----------------------------------------------------------------------------
// ptd_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates the vector by +/- atan(2^-STAGE) toward a zero residual angle and
// hands the vector and the transaction's point on to the next cell.
// ----------------------------------------------------------------------------
module ptd_cordic_cell #(
  parameter int COORD_WIDTH = 32,
  parameter int STAGE       = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ptd_pkg::ptd_ctrl_t              ctrl_in,
  input  logic signed [ptd_pkg::XY_W-1:0] x_in,
  input  logic signed [ptd_pkg::XY_W-1:0] y_in,
  input  logic signed [ptd_pkg::Z_W-1:0]  z_in,
  input  logic signed [COORD_WIDTH:0]     vx_in,
  input  logic signed [COORD_WIDTH:0]     vy_in,
  input  logic signed [COORD_WIDTH:0]     vz_in,
  output logic                            ready,
  input  logic                            ready_next,
  output ptd_pkg::ptd_ctrl_t              ctrl_out,
  output logic signed [ptd_pkg::XY_W-1:0] x_out,
  output logic signed [ptd_pkg::XY_W-1:0] y_out,
  output logic signed [ptd_pkg::Z_W-1:0]  z_out,
  output logic signed [COORD_WIDTH:0]     vx_out,
  output logic signed [COORD_WIDTH:0]     vy_out,
  output logic signed [COORD_WIDTH:0]     vz_out
);

  localparam logic signed [ptd_pkg::Z_W-1:0] ATAN = ptd_pkg::atan_q28(STAGE);

  logic signed [ptd_pkg::XY_W-1:0] xs, ys, x_next, y_next;
  logic signed [ptd_pkg::Z_W-1:0]  z_next;

  assign ready = !ctrl_out.valid || ready_next;
  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  always_comb begin
    if (!z_in[ptd_pkg::Z_W-1]) begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN;
    end else begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (ready) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      ctrl_out.mode <= ctrl_in.mode;
      ctrl_out.neg  <= ctrl_in.neg;
      x_out  <= x_next;
      y_out  <= y_next;
      z_out  <= z_next;
      vx_out <= vx_in;
      vy_out <= vy_in;
      vz_out <= vz_in;
    end
  end

endmodule

>>> design/ptd_rotate.sv
// ----------------------------------------------------------------------------
// ptd_rotate: rotation and saturation back end of the 3D point transform
// Rounds the CORDIC vector to Q16 sine and cosine, forms the two rotated
// components with four multipliers, places them by axis and clamps the result.
// ----------------------------------------------------------------------------
module ptd_rotate #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ptd_pkg::ptd_ctrl_t              ctrl_in,
  input  logic signed [ptd_pkg::XY_W-1:0] x_in,
  input  logic signed [ptd_pkg::XY_W-1:0] y_in,
  input  logic signed [COORD_WIDTH:0]     vx_in,
  input  logic signed [COORD_WIDTH:0]     vy_in,
  input  logic signed [COORD_WIDTH:0]     vz_in,
  output logic                            ready,
  ptd_out_if.source                       image_out
);

  localparam int PW = COORD_WIDTH + ptd_pkg::K_W;   // product width
  localparam int SW = PW + 1;                      // sum of two products
  localparam int RW = COORD_WIDTH + 3;             // rounded result width
  localparam int EW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam logic signed [SW-1:0] ROUND_Q16 = SW'(32768);
  localparam logic signed [RW-1:0] HI = {{4{1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] LO = {{4{1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  // Stage 0: sine and cosine, multiplier operands.
  logic                                v0;
  ptd_pkg::ptd_mode_t                  m0;
  logic signed [ptd_pkg::K_W-1:0]      cos0, sin0, cos_next, sin_next;
  logic signed [COORD_WIDTH-1:0]       a0, b0, a_next, b_next;
  logic signed [COORD_WIDTH:0]         vx0, vy0, vz0;
  logic signed [ptd_pkg::XY_W-1:0]     xr, yr, xq, yq;
  // Stage 1: products.
  logic                                v1;
  ptd_pkg::ptd_mode_t                  m1;
  logic signed [PW-1:0]                pac, pbs, pas, pbc;
  logic signed [COORD_WIDTH:0]         vx1, vy1, vz1;
  // Stage 2: placed components.
  logic                                v2;
  logic signed [RW-1:0]                r2 [3];
  logic signed [RW-1:0]                r_next [3];
  logic signed [SW-1:0]                su, sv;
  logic signed [RW-1:0]                u, v;
  // Stage 3: clamped output.
  logic signed [COORD_WIDTH-1:0]       clamped [3];
  logic signed [EW-1:0]                widened [3];
  logic [2:0]                          clip;
  logic                                out_valid;
  logic signed [31:0]                  out_x, out_y, out_z;
  logic                                out_sat;
  logic                                en0, en1, en2, en3;

  assign en3 = !out_valid || image_out.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign ready = en0;

  always_comb begin
    xr = x_in + ptd_pkg::ROUND_Q14;
    yr = y_in + ptd_pkg::ROUND_Q14;
    xq = xr >>> 14;
    yq = yr >>> 14;
    cos_next = ctrl_in.neg ? -xq[ptd_pkg::K_W-1:0] : xq[ptd_pkg::K_W-1:0];
    sin_next = ctrl_in.neg ? -yq[ptd_pkg::K_W-1:0] : yq[ptd_pkg::K_W-1:0];
    // Rotating pair (a, b): (y, z) about x, (x, z) about y, (x, y) about z.
    a_next = (ctrl_in.mode == ptd_pkg::MODE_ROT_X) ? vy_in[COORD_WIDTH-1:0]
                                                   : vx_in[COORD_WIDTH-1:0];
    b_next = (ctrl_in.mode == ptd_pkg::MODE_ROT_Z) ? vy_in[COORD_WIDTH-1:0]
                                                   : vz_in[COORD_WIDTH-1:0];
  end

  always_comb begin
    su = SW'(pac) - SW'(pbs) + ROUND_Q16;
    sv = SW'(pas) + SW'(pbc) + ROUND_Q16;
    u = RW'(su >>> 16);
    v = RW'(sv >>> 16);
    r_next[0] = RW'(vx1);
    r_next[1] = RW'(vy1);
    r_next[2] = RW'(vz1);
    case (m1)
      ptd_pkg::MODE_ROT_X: begin
        r_next[1] = u;
        r_next[2] = v;
      end
      ptd_pkg::MODE_ROT_Y: begin
        r_next[0] = u;
        r_next[2] = v;
      end
      ptd_pkg::MODE_ROT_Z: begin
        r_next[0] = u;
        r_next[1] = v;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (r2[i] > HI) begin
        clamped[i] = HI[COORD_WIDTH-1:0];
        clip[i] = 1'b1;
      end else if (r2[i] < LO) begin
        clamped[i] = LO[COORD_WIDTH-1:0];
        clip[i] = 1'b1;
      end else begin
        clamped[i] = r2[i][COORD_WIDTH-1:0];
        clip[i] = 1'b0;
      end
      widened[i] = EW'(clamped[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= ctrl_in.valid;
      end
      if (en1) begin
        v1 <= v0;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      m0   <= ctrl_in.mode;
      cos0 <= cos_next;
      sin0 <= sin_next;
      a0   <= a_next;
      b0   <= b_next;
      vx0  <= vx_in;
      vy0  <= vy_in;
      vz0  <= vz_in;
    end
    if (en1) begin
      m1  <= m0;
      pac <= PW'(a0) * PW'(cos0);
      pbs <= PW'(b0) * PW'(sin0);
      pas <= PW'(a0) * PW'(sin0);
      pbc <= PW'(b0) * PW'(cos0);
      vx1 <= vx0;
      vy1 <= vy0;
      vz1 <= vz0;
    end
    if (en2) begin
      r2 <= r_next;
    end
    if (en3) begin
      out_x   <= widened[0][31:0];
      out_y   <= widened[1][31:0];
      out_z   <= widened[2][31:0];
      out_sat <= |clip;
    end
  end

  assign image_out.valid     = out_valid;
  assign image_out.image_x   = out_x;
  assign image_out.image_y   = out_y;
  assign image_out.image_z   = out_z;
  assign image_out.saturated = out_sat;

endmodule

>>> design/point_transform_3d_core.sv
// ----------------------------------------------------------------------------
// point_transform_3d_core: affine transform of one 3D point per transaction
// Translation, or rotation about the x, y or z axis with a pipelined CORDIC.
// ----------------------------------------------------------------------------
// The core takes one point every clock cycle when the output is not stalled,
// and returns the images in order through a pipeline of one entry
// stage for angle reduction and translation, one cell for each CORDIC stage,
// and four back-end stages for rounding, multiplication, placement and
// saturation. Every stage holds its own valid bit and advances whenever the
// stage after it is empty or moving, so an image waiting on the output does
// not stop new points from filling empty stages behind it.
module point_transform_3d_core #(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk,
  input  logic       rst,
  ptd_in_if.sink     point_in,
  ptd_out_if.source  image_out
);

  localparam int N = CORDIC_STAGES;

  ptd_pkg::ptd_ctrl_t              ctrl_c [N+1];
  logic signed [ptd_pkg::XY_W-1:0] x_c    [N+1];
  logic signed [ptd_pkg::XY_W-1:0] y_c    [N+1];
  logic signed [ptd_pkg::Z_W-1:0]  z_c    [N+1];
  logic signed [COORD_WIDTH:0]     vx_c   [N+1];
  logic signed [COORD_WIDTH:0]     vy_c   [N+1];
  logic signed [COORD_WIDTH:0]     vz_c   [N+1];
  logic                            rdy_c  [N+1];

  ptd_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .point_in   (point_in),
    .ready_next (rdy_c[0]),
    .ctrl       (ctrl_c[0]),
    .x          (x_c[0]),
    .y          (y_c[0]),
    .z          (z_c[0]),
    .vx         (vx_c[0]),
    .vy         (vy_c[0]),
    .vz         (vz_c[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    ptd_cordic_cell #(
      .COORD_WIDTH(COORD_WIDTH),
      .STAGE      (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl_in    (ctrl_c[i]),
      .x_in       (x_c[i]),
      .y_in       (y_c[i]),
      .z_in       (z_c[i]),
      .vx_in      (vx_c[i]),
      .vy_in      (vy_c[i]),
      .vz_in      (vz_c[i]),
      .ready      (rdy_c[i]),
      .ready_next (rdy_c[i+1]),
      .ctrl_out   (ctrl_c[i+1]),
      .x_out      (x_c[i+1]),
      .y_out      (y_c[i+1]),
      .z_out      (z_c[i+1]),
      .vx_out     (vx_c[i+1]),
      .vy_out     (vy_c[i+1]),
      .vz_out     (vz_c[i+1])
    );
  end

  // The residual angle of the last cell is not needed.
  ptd_rotate #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .ctrl_in   (ctrl_c[N]),
    .x_in      (x_c[N]),
    .y_in      (y_c[N]),
    .vx_in     (vx_c[N]),
    .vy_in     (vy_c[N]),
    .vz_in     (vz_c[N]),
    .ready     (rdy_c[N]),
    .image_out (image_out)
  );

endmodule

>>> design/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_checker: port-level checks of the 3D point transform
// Watches both channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module ptd_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic              out_sat
);

  localparam int EW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam logic signed [EW-1:0] HI_E =
    EW'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
  localparam logic signed [EW-1:0] LO_E =
    EW'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}));
  localparam logic [31:0] HI32 = HI_E[31:0];
  localparam logic [31:0] LO32 = LO_E[31:0];

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("image channel valid right after reset");

  // With the output register free to move, every stage can move.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("point channel stalled while the image channel drains");

  // A clamped transaction shows at least one component at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |->
      (out_x == HI32 || out_x == LO32 || out_y == HI32 || out_y == LO32 ||
       out_z == HI32 || out_z == LO32))
    else $error("saturation flag without a clamped component");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) &&
       $stable(out_sat)))
    else $error("stalled image transaction changed");

  // Ready on the point channel is known right after each point transaction.
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$isunknown(in_ready))
    else $error("point channel ready unknown after a transaction");

endmodule

bind point_transform_3d_core ptd_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_ptd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (point_in.valid),
  .in_ready  (point_in.ready),
  .out_valid (image_out.valid),
  .out_ready (image_out.ready),
  .out_x     (image_out.image_x),
  .out_y     (image_out.image_y),
  .out_z     (image_out.image_z),
  .out_sat   (image_out.saturated)
);
